// ===== design/aob_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// aob_pkg
// Shared widths, constants, stage payload types and helpers for the alpha
// over blend pipeline.
// ============================================================================
package aob_pkg;

    localparam int unsigned CHAN_W        = 16;  // color channel, Q4.12
    localparam int unsigned ALPHA_W       = 13;  // alpha, Q1.12, 0..4096
    localparam int unsigned PROD_W        = 28;  // channel times alpha
    localparam int unsigned DIV_W         = 25;  // exact new alpha, 0..2^24
    localparam int unsigned REM_W         = 24;  // partial remainder, below divisor
    localparam int unsigned NUM_W         = 40;  // channel numerator
    localparam int unsigned LANES         = 3;   // red, green, blue
    localparam int unsigned DEF_DIV_BITS  = 2;   // quotient bits per divider stage

    localparam logic [ALPHA_W-1:0] ONE_Q12 = ALPHA_W'(4096);

    typedef logic [LANES-1:0][CHAN_W-1:0] t_chan_vec;

    // One lane of the long division: remainder and a shift word that holds
    // the unused numerator bits at the top and the quotient bits at the bottom.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [CHAN_W-1:0] sh;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [LANES-1:0] lane;
        logic [DIV_W-1:0]      divisor;
        logic [ALPHA_W-1:0]    alpha;
        logic                  zero;
    } t_div_bus;

    // Alpha codes above one saturate to one.
    function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] a);
        return (a > ONE_Q12) ? ONE_Q12 : a;
    endfunction

endpackage

// ===== design/aob_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// aob_front
// Two register stages: the products of colors and alphas, then the exact
// new alpha and the channel numerators, packed for the divider.
// ============================================================================
module aob_front (
    input  logic                     i_clk,
    input  logic [1:0]               i_load,
    input  aob_pkg::t_chan_vec       i_base_chan,
    input  logic [aob_pkg::ALPHA_W-1:0] i_base_alpha,
    input  aob_pkg::t_chan_vec       i_top_chan,
    input  logic [aob_pkg::ALPHA_W-1:0] i_top_alpha,
    output aob_pkg::t_div_bus        o_bus
);
    import aob_pkg::*;

    // Stage one registers.
    logic [ALPHA_W-1:0]            r_ab;
    logic [ALPHA_W-1:0]            r_am;
    logic [DIV_W-1:0]              r_abam;
    logic [ALPHA_W-1:0]            r_inv_am;
    logic [LANES-1:0][PROD_W-1:0]  r_cm_am;
    logic [LANES-1:0][PROD_W-1:0]  r_cb_ab;

    logic [ALPHA_W-1:0]            n_ab;
    logic [ALPHA_W-1:0]            n_am;

    // Stage two register.
    t_div_bus                      r_bus;
    t_div_bus                      n_bus;

    assign n_ab = clamp_alpha(i_base_alpha);
    assign n_am = clamp_alpha(i_top_alpha);

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_ab     <= n_ab;
            r_am     <= n_am;
            r_abam   <= DIV_W'({13'd0, n_ab} * {13'd0, n_am});
            r_inv_am <= ONE_Q12 - n_am;
            for (int l = 0; l < LANES; l++) begin
                r_cm_am[l] <= PROD_W'({12'd0, i_top_chan[l]} * {15'd0, n_am});
                r_cb_ab[l] <= PROD_W'({12'd0, i_base_chan[l]} * {15'd0, n_ab});
            end
        end
    end

    always_comb begin
        logic [DIV_W:0] a_wide;
        logic [NUM_W:0] n_wide;
        n_bus = '0;
        a_wide = {1'b0, r_ab, 12'd0} + {1'b0, r_am, 12'd0} - {1'b0, r_abam};
        n_bus.divisor = a_wide[DIV_W-1:0];
        n_bus.alpha   = a_wide[DIV_W-1:12];
        n_bus.zero    = (a_wide[DIV_W-1:0] == '0);
        for (int l = 0; l < LANES; l++) begin
            n_wide = {1'b0, r_cm_am[l], 12'd0}
                   + ((NUM_W + 1)'(r_cb_ab[l]) * (NUM_W + 1)'(r_inv_am));
            // The numerator is below 65536 times the divisor, so its upper
            // part already is a valid starting remainder.
            n_bus.lane[l].rem = n_wide[NUM_W-1:CHAN_W];
            n_bus.lane[l].sh  = n_wide[CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ===== design/aob_div_stage.sv =====
`timescale 1ns / 1ps
// ============================================================================
// aob_div_stage
// One register stage of the restoring divider: P_BITS quotient bits for
// each of the three color lanes against the shared divisor.
// ============================================================================
module aob_div_stage #(
    parameter int unsigned P_BITS = aob_pkg::DEF_DIV_BITS
) (
    input  logic               i_clk,
    input  logic               i_load,
    input  aob_pkg::t_div_bus  i_bus,
    output aob_pkg::t_div_bus  o_bus
);
    import aob_pkg::*;

    t_div_bus r_bus;
    t_div_bus n_bus;

    always_comb begin
        logic [REM_W-1:0]  cur_rem;
        logic [CHAN_W-1:0] cur_sh;
        logic [DIV_W-1:0]  trial;
        logic              q_bit;
        n_bus = i_bus;
        for (int l = 0; l < LANES; l++) begin
            cur_rem = i_bus.lane[l].rem;
            cur_sh  = i_bus.lane[l].sh;
            for (int s = 0; s < P_BITS; s++) begin
                trial = {cur_rem, cur_sh[CHAN_W-1]};
                q_bit = (trial >= i_bus.divisor);
                if (q_bit) begin
                    cur_rem = REM_W'(trial - i_bus.divisor);
                end else begin
                    cur_rem = trial[REM_W-1:0];
                end
                cur_sh = {cur_sh[CHAN_W-2:0], q_bit};
            end
            n_bus.lane[l].rem = cur_rem;
            n_bus.lane[l].sh  = cur_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ===== design/alpha_over_blend.sv =====
`timescale 1ns / 1ps
// ============================================================================
// alpha_over_blend
// Porter-Duff over of a top color onto a base color, straight alpha, Q4.12.
// ============================================================================
// The block accepts one request per clock while the pipe is not stalled
// and returns one composited color per request, in order. It computes the
// color and alpha products, then the exact new alpha and the channel
// numerators, then runs a restoring divider with P_DIV_BITS quotient bits
// per register stage. The divider depth is set by the 16-bit quotient and
// P_DIV_BITS. Every stage carries its own valid bit and the ready signal
// ripples back stage by stage, so empty stages fill even while the output
// is stalled and no request is lost or repeated. Alpha codes above 4096 are
// treated as 4096. When both alphas are zero the result is fully transparent
// and all outputs are zero. The quotient never exceeds 65535 because each
// channel is at most 65535, so the result is the truncated quotient
// without further saturation.
// ============================================================================
module alpha_over_blend #(
    parameter int unsigned P_DIV_BITS = aob_pkg::DEF_DIV_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [aob_pkg::CHAN_W-1:0]   i_base_red,
    input  logic [aob_pkg::CHAN_W-1:0]   i_base_green,
    input  logic [aob_pkg::CHAN_W-1:0]   i_base_blue,
    input  logic [aob_pkg::ALPHA_W-1:0]  i_base_alpha,
    input  logic [aob_pkg::CHAN_W-1:0]   i_top_red,
    input  logic [aob_pkg::CHAN_W-1:0]   i_top_green,
    input  logic [aob_pkg::CHAN_W-1:0]   i_top_blue,
    input  logic [aob_pkg::ALPHA_W-1:0]  i_top_alpha,

    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [aob_pkg::CHAN_W-1:0]   o_out_red,
    output logic [aob_pkg::CHAN_W-1:0]   o_out_green,
    output logic [aob_pkg::CHAN_W-1:0]   o_out_blue,
    output logic [aob_pkg::ALPHA_W-1:0]  o_out_alpha
);
    import aob_pkg::*;

    // Divider stages needed for the full quotient, plus the two front stages.
    localparam int unsigned NDIV = CHAN_W / P_DIV_BITS;
    localparam int unsigned NS   = NDIV + 2;

    logic [NS-1:0] r_valid;
    logic [NS:0]   w_ready;   // w_ready[k]: stage k may load this cycle
    logic [NS-1:0] w_up;      // valid presented to stage k
    logic [NS-1:0] w_load;

    t_chan_vec     w_base_chan;
    t_chan_vec     w_top_chan;
    t_div_bus      w_bus [NDIV+1];
    t_div_bus      w_last;

    // ------------------------------------------------------------------
    // Handshake: a stage loads when it is empty or its contents move on.
    // ------------------------------------------------------------------
    assign w_up = {r_valid[NS-2:0], i_in_valid};

    always_comb begin
        w_ready[NS] = i_out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_ready[k] = !r_valid[k] || w_ready[k+1];
        end
    end

    assign w_load = w_ready[NS-1:0] & w_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_ready[k]) begin
                    r_valid[k] <= w_up[k];
                end
            end
        end
    end

    assign o_in_ready = w_ready[0];

    // ------------------------------------------------------------------
    // Datapath: products and numerators, then the divider chain.
    // ------------------------------------------------------------------
    assign w_base_chan = {i_base_blue, i_base_green, i_base_red};
    assign w_top_chan  = {i_top_blue, i_top_green, i_top_red};

    aob_front u_front (
        .i_clk        (i_clk),
        .i_load       (w_load[1:0]),
        .i_base_chan  (w_base_chan),
        .i_base_alpha (i_base_alpha),
        .i_top_chan   (w_top_chan),
        .i_top_alpha  (i_top_alpha),
        .o_bus        (w_bus[0])
    );

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        aob_div_stage #(
            .P_BITS (P_DIV_BITS)
        ) u_div (
            .i_clk  (i_clk),
            .i_load (w_load[g+2]),
            .i_bus  (w_bus[g]),
            .o_bus  (w_bus[g+1])
        );
    end

    // After the last stage the shift word holds the whole quotient. A zero
    // divisor only happens with both alphas zero; the result is then forced
    // to transparent black.
    assign w_last = w_bus[NDIV];

    assign o_out_valid = r_valid[NS-1];
    assign o_out_red   = w_last.zero ? '0 : w_last.lane[0].sh;
    assign o_out_green = w_last.zero ? '0 : w_last.lane[1].sh;
    assign o_out_blue  = w_last.zero ? '0 : w_last.lane[2].sh;
    assign o_out_alpha = w_last.alpha;

`ifndef NO_ASSERTIONS
    // A fully transparent result carries no color.
    a_transparent_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_alpha == '0) |->
        (o_out_red == '0 && o_out_green == '0 && o_out_blue == '0))
        else $error("transparent result with nonzero color");

    // The composited alpha never exceeds one.
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_alpha <= ONE_Q12))
        else $error("composited alpha above one");

    // With the output stage empty the whole pipe can take a new request.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[NS-1] |-> o_in_ready)
        else $error("input stalled although the output stage is empty");

    // Restoring division keeps every remainder below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[NS-1] && !w_last.zero) |->
        ({1'b0, w_last.lane[0].rem} < w_last.divisor &&
         {1'b0, w_last.lane[1].rem} < w_last.divisor &&
         {1'b0, w_last.lane[2].rem} < w_last.divisor))
        else $error("divider remainder not below divisor");

    // A request moves one stage per cycle when nothing stalls; here an accepted request must enter the first stage.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_valid[0])
        else $error("accepted request did not enter the first stage");
`endif

endmodule
